// ===== design/jet_pkg.sv =====
// Shared types and constants for the joint encoder tracker.
// Used by every module of the block; depends on nothing else.
package jet_pkg;

	localparam int JOINT_W  = 2;
	localparam int TORQUE_W = 16;
	localparam int SHAFT_W  = 16;
	localparam int ANGLE_W  = 32;
	localparam int LIMIT_W  = 15;
	localparam int MOD_W    = 17;
	localparam int GAIN_W   = 32;
	localparam int DELTA_W  = 18;
	localparam int PROD_W   = 50;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam int WRAP_HIGH = 50000;
	localparam int WRAP_LOW  = -50000;

	localparam logic OP_INIT    = 1'b0;
	localparam logic OP_CONTROL = 1'b1;

	localparam logic [LIMIT_W-1:0] CURRENT_LIMIT_RST = 15'h7FFF;
	localparam logic [MOD_W-1:0]   SHAFT_MODULUS_RST = 17'h10000;

	localparam logic [ANGLE_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
	localparam logic [ANGLE_W-1:0] VEL_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		REG_CURRENT_LIMIT = 2'd0,
		REG_SHAFT_MODULUS = 2'd1,
		REG_ANGLE_GAIN    = 2'd2,
		REG_VELOCITY_GAIN = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic                        opcode;
		logic [JOINT_W-1:0]          joint;
		logic                        ok;
		logic signed [TORQUE_W-1:0]  pid;
		logic signed [TORQUE_W-1:0]  grav;
		logic [SHAFT_W-1:0]          reading;
		logic signed [ANGLE_W-1:0]   init_angle;
	} jet_item_t;

	typedef struct packed {
		logic                        opcode;
		logic [JOINT_W-1:0]          joint;
		logic                        ok;
		logic signed [ANGLE_W-1:0]   init_angle;
		logic signed [TORQUE_W-1:0]  torque;
		logic signed [DELTA_W-1:0]   nd;
	} jet_delta_t;

	typedef struct packed {
		logic                        opcode;
		logic [JOINT_W-1:0]          joint;
		logic                        ok;
		logic signed [ANGLE_W-1:0]   init_angle;
		logic signed [TORQUE_W-1:0]  torque;
		logic signed [PROD_W-1:0]    pa;
		logic signed [PROD_W-1:0]    pv;
	} jet_prod_t;

	typedef struct packed {
		logic [JOINT_W-1:0]          joint;
		logic signed [TORQUE_W-1:0]  torque;
		logic signed [ANGLE_W-1:0]   angle;
		logic signed [ANGLE_W-1:0]   velocity;
	} jet_result_t;

endpackage

// ===== design/jet_unwrap.sv =====
// Stage 1: last shaft reading memory, multiturn unwrap of the shaft delta and torque clamp.
// Depends on jet_pkg.
module jet_unwrap #(
	parameter int JOINTS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  jet_pkg::jet_item_t              item,
	input  logic                            adv_s1,
	input  logic [jet_pkg::LIMIT_W-1:0]     current_limit,
	input  logic [jet_pkg::MOD_W-1:0]       shaft_modulus,
	output jet_pkg::jet_delta_t             delta_s2
);
	import jet_pkg::*;

	localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int IW = (AW > JOINT_W) ? AW : JOINT_W;

	logic [SHAFT_W-1:0]        shaft_mem [JOINTS];
	logic [JOINTS-1:0]         shaft_vld_q;
	jet_item_t                 item_s1;
	logic [SHAFT_W-1:0]        rd_shaft_s1;
	logic                      rd_vld_s1;
	logic                      sw_vld_q;
	logic [JOINT_W-1:0]        sw_joint_q;
	logic [SHAFT_W-1:0]        sw_val_q;
	logic [IW-1:0]             jx_in;
	logic [IW-1:0]             jx_s1;
	logic [AW-1:0]             addr_in;
	logic [AW-1:0]             addr_s1;
	logic [SHAFT_W-1:0]        prev;
	logic signed [16:0]        rawn;
	logic signed [DELTA_W-1:0] rawn_x;
	logic signed [DELTA_W-1:0] mod_x;
	logic signed [DELTA_W-1:0] nd;
	logic signed [16:0]        sum;
	logic signed [16:0]        lim;
	logic signed [16:0]        clamped;
	jet_delta_t                delta_d;

	assign jx_in   = IW'(item.joint);
	assign addr_in = jx_in[AW-1:0];
	assign jx_s1   = IW'(item_s1.joint);
	assign addr_s1 = jx_s1[AW-1:0];

	// Read at acceptance; the stored reading is rewritten when the item leaves stage 1.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			rd_shaft_s1 <= shaft_mem[addr_in];
			rd_vld_s1   <= shaft_vld_q[addr_in];
		end
		if (adv_s1 && item_s1.ok) begin
			shaft_mem[addr_s1] <= item_s1.reading;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shaft_vld_q <= '0;
			sw_vld_q    <= 1'b0;
			sw_joint_q  <= '0;
		end else if (adv_s1 && item_s1.ok) begin
			shaft_vld_q[addr_s1] <= 1'b1;
			sw_vld_q             <= 1'b1;
			sw_joint_q           <= item_s1.joint;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.ok) begin
			sw_val_q <= item_s1.reading;
		end
	end

	// The most recent write may have landed on the same edge as our read.
	always_comb begin
		if (!item_s1.ok) begin
			prev = '0;
		end else if (sw_vld_q && (sw_joint_q == item_s1.joint)) begin
			prev = sw_val_q;
		end else if (rd_vld_s1) begin
			prev = rd_shaft_s1;
		end else begin
			prev = '0;
		end
	end

	// Work with the negated delta so the multiplier output needs no negation.
	always_comb begin
		rawn   = $signed({1'b0, prev}) - $signed({1'b0, item_s1.reading});
		rawn_x = DELTA_W'(rawn);
		mod_x  = $signed({1'b0, shaft_modulus});
		if (rawn < WRAP_LOW) begin
			nd = rawn_x + mod_x;
		end else if (rawn > WRAP_HIGH) begin
			nd = rawn_x - mod_x;
		end else begin
			nd = rawn_x;
		end
	end

	always_comb begin
		sum = 17'(item_s1.pid) + 17'(item_s1.grav);
		lim = $signed({2'b00, current_limit});
		if (sum > lim) begin
			clamped = lim;
		end else if (sum < -lim) begin
			clamped = -lim;
		end else begin
			clamped = sum;
		end
	end

	always_comb begin
		delta_d.opcode     = item_s1.opcode;
		delta_d.joint      = item_s1.joint;
		delta_d.ok         = item_s1.ok;
		delta_d.init_angle = item_s1.init_angle;
		delta_d.nd         = nd;
		if (item_s1.opcode == OP_CONTROL) begin
			delta_d.torque = clamped[TORQUE_W-1:0];
		end else begin
			delta_d.torque = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			delta_s2 <= delta_d;
		end
	end

	a_shaft_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && item_s1.ok) |=> (sw_vld_q && sw_val_q == $past(item_s1.reading)))
		else $error("shaft bypass register missed a write");

endmodule

// ===== design/jet_scale.sv =====
// Stage 2: scales the negated shaft delta by the angle and velocity gains.
// Depends on jet_pkg.
module jet_scale (
	input  logic                        clk,
	input  logic                        adv_s2,
	input  jet_pkg::jet_delta_t         delta_s2,
	input  logic [jet_pkg::GAIN_W-1:0]  angle_gain,
	input  logic [jet_pkg::GAIN_W-1:0]  velocity_gain,
	output jet_pkg::jet_prod_t          prod_s3
);
	import jet_pkg::*;

	logic signed [PROD_W:0] pa_full;
	logic signed [PROD_W:0] pv_full;

	// Signed 18 bit delta times unsigned 32 bit Q8.24 gain; the product fits in 50 bits.
	assign pa_full = delta_s2.nd * $signed({1'b0, angle_gain});
	assign pv_full = delta_s2.nd * $signed({1'b0, velocity_gain});

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			prod_s3.opcode     <= delta_s2.opcode;
			prod_s3.joint      <= delta_s2.joint;
			prod_s3.ok         <= delta_s2.ok;
			prod_s3.init_angle <= delta_s2.init_angle;
			prod_s3.torque     <= delta_s2.torque;
			prod_s3.pa         <= pa_full[PROD_W-1:0];
			prod_s3.pv         <= pv_full[PROD_W-1:0];
		end
	end

endmodule

// ===== design/jet_accum.sv =====
// Stage 3: joint angle memory, angle accumulation, velocity saturation and the result register.
// Depends on jet_pkg.
module jet_accum #(
	parameter int JOINTS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv_s2,
	input  jet_pkg::jet_delta_t   delta_s2,
	input  logic                  adv_s3,
	input  jet_pkg::jet_prod_t    prod_s3,
	output jet_pkg::jet_result_t  result_q
);
	import jet_pkg::*;

	localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int IW = (AW > JOINT_W) ? AW : JOINT_W;

	logic [ANGLE_W-1:0]   angle_mem [JOINTS];
	logic [JOINTS-1:0]    angle_vld_q;
	logic [ANGLE_W-1:0]   rd_angle_s3;
	logic                 rd_vld_s3;
	logic                 aw_vld_q;
	logic [JOINT_W-1:0]   aw_joint_q;
	logic [ANGLE_W-1:0]   aw_val_q;
	logic [IW-1:0]        jx_s2;
	logic [IW-1:0]        jx_s3;
	logic [AW-1:0]        addr_s2;
	logic [AW-1:0]        addr_s3;
	logic [ANGLE_W-1:0]   base;
	logic [ANGLE_W-1:0]   new_angle;
	logic signed [42:0]   vfull;
	logic                 sat_hi;
	logic                 sat_lo;
	logic [ANGLE_W-1:0]   vel;
	jet_result_t          result_d;

	assign jx_s2   = IW'(delta_s2.joint);
	assign addr_s2 = jx_s2[AW-1:0];
	assign jx_s3   = IW'(prod_s3.joint);
	assign addr_s3 = jx_s3[AW-1:0];

	// Read as the item enters stage 3, write back as it leaves.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			rd_angle_s3 <= angle_mem[addr_s2];
			rd_vld_s3   <= angle_vld_q[addr_s2];
		end
		if (adv_s3 && prod_s3.ok) begin
			angle_mem[addr_s3] <= new_angle;
			aw_val_q           <= new_angle;
		end
		if (adv_s3) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_vld_q <= '0;
			aw_vld_q    <= 1'b0;
			aw_joint_q  <= '0;
		end else if (adv_s3 && prod_s3.ok) begin
			angle_vld_q[addr_s3] <= 1'b1;
			aw_vld_q             <= 1'b1;
			aw_joint_q           <= prod_s3.joint;
		end
	end

	always_comb begin
		if (!prod_s3.ok) begin
			base = '0;
		end else if (aw_vld_q && (aw_joint_q == prod_s3.joint)) begin
			base = aw_val_q;
		end else if (rd_vld_s3) begin
			base = rd_angle_s3;
		end else begin
			base = '0;
		end
	end

	// Q8.24 to Q16.16 with round half up: drop 8 bits and add back bit 7.
	always_comb begin
		if (prod_s3.opcode == OP_CONTROL) begin
			new_angle = base + prod_s3.pa[39:8] + ANGLE_W'(prod_s3.pa[7]);
		end else begin
			new_angle = prod_s3.init_angle;
		end
		vfull  = $signed({prod_s3.pv[PROD_W-1], prod_s3.pv[PROD_W-1:8]})
			+ $signed({42'd0, prod_s3.pv[7]});
		sat_hi = !vfull[42] && (vfull[41:31] != '0);
		sat_lo = vfull[42] && (vfull[41:31] != '1);
		if (prod_s3.opcode != OP_CONTROL) begin
			vel = '0;
		end else if (sat_hi) begin
			vel = VEL_MAX;
		end else if (sat_lo) begin
			vel = VEL_MIN;
		end else begin
			vel = vfull[31:0];
		end
		result_d.joint    = prod_s3.joint;
		result_d.torque   = prod_s3.torque;
		result_d.angle    = new_angle;
		result_d.velocity = vel;
	end

	a_angle_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && prod_s3.ok) |=> (aw_vld_q && aw_val_q == $past(new_angle)))
		else $error("angle bypass register missed a write");

	a_init_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && prod_s3.opcode == OP_INIT) |=>
		(result_q.velocity == '0 && result_q.angle == $past(prod_s3.init_angle)))
		else $error("init item produced a wrong result");

endmodule

// ===== design/joint_encoder_tracker.sv =====
// Top level of the joint encoder tracker: handshake, configuration registers and pipeline.
// Depends on jet_pkg, jet_unwrap, jet_scale and jet_accum.
//
//  Channel   Direction  Handshake              Content
//  item      in         item_valid/item_stall  opcode, joint, torque requests, shaft, angle
//  result    out        result_valid/result_stall  joint_out, torque, angle, velocity
//  config    in         APB psel/penable       four registers at byte addresses 0, 4, 8, 12
//
// One item is taken per cycle while item_stall is low; each result passes stages 1, 2
// and 3 and the output register. The throughput is set by the per-joint read-modify-write
// of the two state memories, which forwarding keeps at one item per cycle without stalls,
// even for the same joint back to back. Reset clears the per-entry valid bits, so all
// joints read as zero at once; no clearing pass is needed. A stalled result stalls only
// the full stages behind it: bubbles are squeezed out, input stalls only when all are full.
module joint_encoder_tracker #(
	parameter int JOINTS = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Item channel.
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  opcode,
	input  logic [jet_pkg::JOINT_W-1:0]           joint,
	input  logic signed [jet_pkg::TORQUE_W-1:0]   pid_command,
	input  logic signed [jet_pkg::TORQUE_W-1:0]   gravity_command,
	input  logic [jet_pkg::SHAFT_W-1:0]           shaft_reading,
	input  logic signed [jet_pkg::ANGLE_W-1:0]    initial_angle,
	// Result channel.
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic [jet_pkg::JOINT_W-1:0]           joint_out,
	output logic signed [jet_pkg::TORQUE_W-1:0]   torque_command,
	output logic signed [jet_pkg::ANGLE_W-1:0]    angle_out,
	output logic signed [jet_pkg::ANGLE_W-1:0]    velocity_out,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [jet_pkg::ADDR_W-1:0]            paddr,
	input  logic [jet_pkg::DATA_W-1:0]            pwdata,
	output logic [jet_pkg::DATA_W-1:0]            prdata,
	output logic                                  pready
);
	import jet_pkg::*;

	logic [LIMIT_W-1:0] current_limit_q;
	logic [MOD_W-1:0]   shaft_modulus_q;
	logic [GAIN_W-1:0]  angle_gain_q;
	logic [GAIN_W-1:0]  velocity_gain_q;
	reg_index_t         reg_sel;

	logic        valid_s1;
	logic        valid_s2;
	logic        valid_s3;
	logic        out_valid_q;
	logic        accept;
	logic        adv_s1;
	logic        adv_s2;
	logic        adv_s3;
	jet_item_t   item;
	jet_delta_t  delta_s2;
	jet_prod_t   prod_s3;
	jet_result_t result_q;

	// Configuration registers. A write completes in the APB access phase.
	assign pready  = 1'b1;
	assign reg_sel = reg_index_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_limit_q <= CURRENT_LIMIT_RST;
			shaft_modulus_q <= SHAFT_MODULUS_RST;
			angle_gain_q    <= '0;
			velocity_gain_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_CURRENT_LIMIT: current_limit_q <= pwdata[LIMIT_W-1:0];
				REG_SHAFT_MODULUS: shaft_modulus_q <= pwdata[MOD_W-1:0];
				REG_ANGLE_GAIN:    angle_gain_q    <= pwdata[GAIN_W-1:0];
				REG_VELOCITY_GAIN: velocity_gain_q <= pwdata[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_CURRENT_LIMIT: prdata = DATA_W'(current_limit_q);
			REG_SHAFT_MODULUS: prdata = DATA_W'(shaft_modulus_q);
			REG_ANGLE_GAIN:    prdata = angle_gain_q;
			REG_VELOCITY_GAIN: prdata = velocity_gain_q;
			default:           prdata = '0;
		endcase
	end

	// Pipeline control. Each stage moves when the stage ahead of it is empty or moving,
	// so result_stall reaches item_stall combinationally through the advance signals.
	assign adv_s3     = valid_s3 && (!out_valid_q || !result_stall);
	assign adv_s2     = valid_s2 && (!valid_s3 || adv_s3);
	assign adv_s1     = valid_s1 && (!valid_s2 || adv_s2);
	assign item_stall = valid_s1 && !adv_s1;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept || (valid_s1 && !adv_s1);
			valid_s2    <= adv_s1 || (valid_s2 && !adv_s2);
			valid_s3    <= adv_s2 || (valid_s3 && !adv_s3);
			out_valid_q <= adv_s3 || (out_valid_q && result_stall);
		end
	end

	// A joint index past the table acts on zero state and writes nothing back.
	always_comb begin
		item.opcode     = opcode;
		item.joint      = joint;
		item.ok         = ({30'd0, joint} < JOINTS);
		item.pid        = pid_command;
		item.grav       = gravity_command;
		item.reading    = shaft_reading;
		item.init_angle = initial_angle;
	end

	jet_unwrap #(
		.JOINTS(JOINTS)
	) u_unwrap (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.item          (item),
		.adv_s1        (adv_s1),
		.current_limit (current_limit_q),
		.shaft_modulus (shaft_modulus_q),
		.delta_s2      (delta_s2)
	);

	jet_scale u_scale (
		.clk           (clk),
		.adv_s2        (adv_s2),
		.delta_s2      (delta_s2),
		.angle_gain    (angle_gain_q),
		.velocity_gain (velocity_gain_q),
		.prod_s3       (prod_s3)
	);

	jet_accum #(
		.JOINTS(JOINTS)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv_s2   (adv_s2),
		.delta_s2 (delta_s2),
		.adv_s3   (adv_s3),
		.prod_s3  (prod_s3),
		.result_q (result_q)
	);

	assign result_valid   = out_valid_q;
	assign joint_out      = result_q.joint;
	assign torque_command = result_q.torque;
	assign angle_out      = result_q.angle;
	assign velocity_out   = result_q.velocity;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted item did not reach stage 1");

	a_no_phantom_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && !valid_s3) |=> !out_valid_q)
		else $error("result appeared with no item in stage 3");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_valid_q))
		else $error("item side stalled with a free pipeline slot");

endmodule

// ===== tb/joint_encoder_tracker_checker.sv =====
// Scoreboard for joint_encoder_tracker: follows item, result and APB transfers,
// predicts each result from its own copy of the joint state and registers.
// Depends on jet_pkg.
module joint_encoder_tracker_checker #(
	parameter int JOINTS = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	input  logic                                  item_stall,
	input  logic                                  opcode,
	input  logic [jet_pkg::JOINT_W-1:0]           joint,
	input  logic signed [jet_pkg::TORQUE_W-1:0]   pid_command,
	input  logic signed [jet_pkg::TORQUE_W-1:0]   gravity_command,
	input  logic [jet_pkg::SHAFT_W-1:0]           shaft_reading,
	input  logic signed [jet_pkg::ANGLE_W-1:0]    initial_angle,
	input  logic                                  result_valid,
	input  logic                                  result_stall,
	input  logic [jet_pkg::JOINT_W-1:0]           joint_out,
	input  logic signed [jet_pkg::TORQUE_W-1:0]   torque_command,
	input  logic signed [jet_pkg::ANGLE_W-1:0]    angle_out,
	input  logic signed [jet_pkg::ANGLE_W-1:0]    velocity_out,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [jet_pkg::ADDR_W-1:0]            paddr,
	input  logic [jet_pkg::DATA_W-1:0]            pwdata,
	input  logic [jet_pkg::DATA_W-1:0]            prdata,
	input  logic                                  pready,
	output int                                    failures,
	output int                                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import jet_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic [MOD_W-1:0]   modulus_q;
	logic [GAIN_W-1:0]  angle_gain_q;
	logic [GAIN_W-1:0]  velocity_gain_q;
	logic [SHAFT_W-1:0] shaft_q [JOINTS];
	logic [ANGLE_W-1:0] angle_q [JOINTS];
	jet_result_t        feedback_q [$];
	int                 fail_total;

	// Negated Q8.24 product brought to Q16.16, rounding half toward plus infinity.
	function automatic longint neg_q16(longint d, logic [GAIN_W-1:0] gain);
		return (longint'(128) - d * longint'(gain)) >>> 8;
	endfunction

	function automatic jet_result_t track_joint(logic op, logic [JOINT_W-1:0] j,
			logic signed [TORQUE_W-1:0] pid, logic signed [TORQUE_W-1:0] grav,
			logic [SHAFT_W-1:0] reading, logic signed [ANGLE_W-1:0] start);
		bit                 ok;
		logic [SHAFT_W-1:0] prev;
		logic [ANGLE_W-1:0] ang;
		longint             lim, sum, raw, d, vel;
		jet_result_t        r;
		ok = j < JOINTS;
		prev = ok ? shaft_q[j] : '0;
		ang = ok ? angle_q[j] : '0;
		r = '0;
		r.joint = j;
		if (op == OP_INIT) begin
			ang = start;
		end else begin
			lim = longint'(limit_q);
			sum = longint'(pid) + longint'(grav);
			if (sum > lim)
				sum = lim;
			if (sum < -lim)
				sum = -lim;
			// Shaft unwrap: a jump of more than the threshold either way is a turn.
			raw = longint'(reading) - longint'(prev);
			if (raw > WRAP_HIGH)
				d = raw - longint'(modulus_q);
			else if (raw < WRAP_LOW)
				d = raw + longint'(modulus_q);
			else
				d = raw;
			ang = ang + ANGLE_W'(neg_q16(d, angle_gain_q));
			vel = neg_q16(d, velocity_gain_q);
			if (vel > longint'(signed'(VEL_MAX)))
				vel = longint'(signed'(VEL_MAX));
			if (vel < longint'(signed'(VEL_MIN)))
				vel = longint'(signed'(VEL_MIN));
			r.torque = TORQUE_W'(sum);
			r.velocity = ANGLE_W'(vel);
		end
		if (ok) begin
			shaft_q[j] = reading;
			angle_q[j] = ang;
		end
		r.angle = ang;
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] reg_readback(reg_index_t idx);
		case (idx)
			REG_CURRENT_LIMIT: return DATA_W'(limit_q);
			REG_SHAFT_MODULUS: return DATA_W'(modulus_q);
			REG_ANGLE_GAIN:    return angle_gain_q;
			default:           return velocity_gain_q;
		endcase
	endfunction

	task automatic compare_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		jet_result_t want;
		if (!arst_n) begin
			limit_q = CURRENT_LIMIT_RST;
			modulus_q = SHAFT_MODULUS_RST;
			angle_gain_q = '0;
			velocity_gain_q = '0;
			for (int i = 0; i < JOINTS; i++) begin
				shaft_q[i] = '0;
				angle_q[i] = '0;
			end
			feedback_q.delete();
			fail_total = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			// Results first, so an item taken on this edge cannot cover a stray result.
			if (result_valid && !result_stall) begin
				if (feedback_q.size() == 0) begin
					$error("result for joint %0d with nothing expected", joint_out);
					fail_total++;
				end else begin
					want = feedback_q.pop_front();
					compare_field("joint_out", longint'(want.joint), longint'(joint_out));
					compare_field("torque_command", longint'(want.torque),
						longint'(torque_command));
					compare_field("angle_out", longint'(want.angle), longint'(angle_out));
					compare_field("velocity_out", longint'(want.velocity),
						longint'(velocity_out));
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (reg_index_t'(paddr[ADDR_W-1:2]))
						REG_CURRENT_LIMIT: limit_q = pwdata[LIMIT_W-1:0];
						REG_SHAFT_MODULUS: modulus_q = pwdata[MOD_W-1:0];
						REG_ANGLE_GAIN:    angle_gain_q = pwdata;
						REG_VELOCITY_GAIN: velocity_gain_q = pwdata;
						default: ;
					endcase
				end else begin
					compare_field("prdata",
						longint'(reg_readback(reg_index_t'(paddr[ADDR_W-1:2]))),
						longint'(prdata));
				end
			end
			if (item_valid && !item_stall)
				feedback_q.push_back(track_joint(opcode, joint, pid_command,
					gravity_command, shaft_reading, initial_angle));
			failures <= fail_total;
			outstanding <= feedback_q.size();
		end
	end

endmodule

// ===== tb/joint_encoder_tracker_tb.sv =====
// Top of the joint_encoder_tracker testbench: clock, reset, item and APB stimulus.
// Depends on jet_pkg, the block itself and joint_encoder_tracker_checker.
module joint_encoder_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import jet_pkg::*;

	localparam int JOINTS          = 4;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 300;

	logic                        clk;
	logic                        arst_n;
	logic                        item_valid;
	logic                        item_stall;
	logic                        opcode;
	logic [JOINT_W-1:0]          joint;
	logic signed [TORQUE_W-1:0]  pid_command;
	logic signed [TORQUE_W-1:0]  gravity_command;
	logic [SHAFT_W-1:0]          shaft_reading;
	logic signed [ANGLE_W-1:0]   initial_angle;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic [JOINT_W-1:0]          joint_out;
	logic signed [TORQUE_W-1:0]  torque_command;
	logic signed [ANGLE_W-1:0]   angle_out;
	logic signed [ANGLE_W-1:0]   velocity_out;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [ADDR_W-1:0]           paddr;
	logic [DATA_W-1:0]           pwdata;
	logic [DATA_W-1:0]           prdata;
	logic                        pready;

	// Failure count and number of results still owed, both from the checker.
	int failures;
	int outstanding;

	// When set, the sender inserts idle gaps and the receiver stalls in bursts.
	bit gaps_on = 1'b1;
	int stall_left = 0;

	// Last shaft reading sent per joint, so that random readings can be placed
	// close to the unwrap thresholds relative to the stored value.
	logic [SHAFT_W-1:0] sent_shaft [JOINTS];

	joint_encoder_tracker #(.JOINTS(JOINTS)) i_dut (.*);

	joint_encoder_tracker_checker #(.JOINTS(JOINTS)) i_checker (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Result side: stall bursts separated by random gaps.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			result_stall <= 1'b0;
			if (gaps_on && $urandom_range(0, 5) == 0)
				stall_left <= $urandom_range(1, 7);
		end
	end

	// One APB transfer: setup phase, access phase until pready, then an idle phase
	// with psel low so that the next transfer never assigns psel twice in one time step.
	task automatic cfg_access(bit wr, reg_index_t idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes all four registers and reads them back; the checker compares the reads.
	task automatic configure(logic [DATA_W-1:0] limit, logic [DATA_W-1:0] modulus,
			logic [DATA_W-1:0] a_gain, logic [DATA_W-1:0] v_gain);
		cfg_access(1'b1, REG_CURRENT_LIMIT, limit);
		cfg_access(1'b1, REG_SHAFT_MODULUS, modulus);
		cfg_access(1'b1, REG_ANGLE_GAIN, a_gain);
		cfg_access(1'b1, REG_VELOCITY_GAIN, v_gain);
		cfg_access(1'b0, REG_CURRENT_LIMIT, '0);
		cfg_access(1'b0, REG_SHAFT_MODULUS, '0);
		cfg_access(1'b0, REG_ANGLE_GAIN, '0);
		cfg_access(1'b0, REG_VELOCITY_GAIN, '0);
	endtask

	// Stops sending and waits until every result has been transferred. The
	// first edge lets the checker count an item taken on the edge just passed.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Presents one item, optionally after an idle gap, and holds it until the
	// transfer happens. The payload stays put while the block stalls.
	task automatic put_item(logic op, logic [JOINT_W-1:0] j, logic signed [TORQUE_W-1:0] pid,
			logic signed [TORQUE_W-1:0] grav, logic [SHAFT_W-1:0] shaft,
			logic signed [ANGLE_W-1:0] start);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		joint <= j;
		pid_command <= pid;
		gravity_command <= grav;
		shaft_reading <= shaft;
		initial_angle <= start;
		do @(posedge clk); while (item_stall);
		sent_shaft[j] = shaft;
	endtask

	function automatic logic signed [TORQUE_W-1:0] pick_torque();
		case ($urandom_range(0, 7))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			default: return TORQUE_W'($urandom);
		endcase
	endfunction

	// Random item. Most readings stay near the joint's last reading or land around
	// the unwrap thresholds; the rest are the shaft extremes or fully random.
	task automatic random_item();
		logic                       op;
		logic [JOINT_W-1:0]         j;
		logic signed [TORQUE_W-1:0] pid, grav;
		logic [SHAFT_W-1:0]         shaft, prev;
		logic signed [ANGLE_W-1:0]  start;
		op = ($urandom_range(0, 4) == 0) ? OP_INIT : OP_CONTROL;
		j = JOINT_W'($urandom_range(0, JOINTS - 1));
		pid = pick_torque();
		grav = pick_torque();
		prev = sent_shaft[j];
		case ($urandom_range(0, 5))
			0, 1:    shaft = prev + SHAFT_W'($urandom_range(0, 2000)) - 16'd1000;
			2:       shaft = prev + 16'd49990 + SHAFT_W'($urandom_range(0, 20));
			3:       shaft = prev - 16'd50010 + SHAFT_W'($urandom_range(0, 20));
			4:       shaft = $urandom_range(0, 1) ? '1 : '0;
			default: shaft = SHAFT_W'($urandom);
		endcase
		if ($urandom_range(0, 7) == 0)
			start = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		else
			start = ANGLE_W'($urandom);
		put_item(op, j, pid, grav, shaft, start);
	endtask

	initial begin
		item_valid <= 1'b0;
		opcode <= OP_INIT;
		joint <= '0;
		pid_command <= '0;
		gravity_command <= '0;
		shaft_reading <= '0;
		initial_angle <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		for (int i = 0; i < JOINTS; i++)
			sent_shaft[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values of the registers, then a transfer pair with zero gains:
		// the angle must not move and the torque sum clamps at the reset limit.
		cfg_access(1'b0, REG_CURRENT_LIMIT, '0);
		cfg_access(1'b0, REG_SHAFT_MODULUS, '0);
		cfg_access(1'b0, REG_ANGLE_GAIN, '0);
		cfg_access(1'b0, REG_VELOCITY_GAIN, '0);
		put_item(OP_INIT, 0, 100, -100, 16'd1234, 32'sh0001_0000);
		put_item(OP_CONTROL, 0, 32767, 32767, 16'd1300, 0);
		drain();

		// Unit gains and a small limit. Joint 0 walks through the unwrap
		// thresholds: exactly at plus and minus 50000 the delta is kept, one
		// count beyond it wraps, and a full-scale jump wraps to a single count.
		configure(1000, 65536, 32'h0100_0000, 32'h0100_0000);
		put_item(OP_INIT, 0, 30000, 30000, 16'd0, 32'sh0000_0000);
		put_item(OP_CONTROL, 0, 30000, 30000, 16'd100, 0);
		put_item(OP_CONTROL, 0, -30000, -30000, 16'd50100, 0);
		put_item(OP_CONTROL, 0, 0, 0, 16'd100, 0);
		put_item(OP_CONTROL, 0, 0, 0, 16'd50101, 0);
		put_item(OP_CONTROL, 0, 0, 0, 16'd100, 0);
		put_item(OP_CONTROL, 0, 0, 0, 16'd65535, 0);
		put_item(OP_CONTROL, 0, 0, 0, 16'd0, 0);
		// Angle extremes on init, and a torque sum that stays inside the limit.
		put_item(OP_INIT, 3, 0, 0, 16'd65535, 32'sh7FFF_FFFF);
		put_item(OP_CONTROL, 3, 500, 499, 16'd65535, 0);
		put_item(OP_CONTROL, 3, 0, 0, 16'd0, 0);
		put_item(OP_INIT, 2, 0, 0, 16'd32768, 32'sh8000_0000);
		put_item(OP_CONTROL, 2, -32768, 0, 16'd32767, 0);
		// Joint 1 has never been initialized, so its stored state is all zero.
		put_item(OP_CONTROL, 1, -32768, -32768, 16'd1, 0);
		drain();

		// Zero limit, zero modulus and full-scale gains: the torque is forced
		// to zero, the unwrap leaves the delta alone and the velocity saturates
		// in both directions.
		configure(0, 0, '1, '1);
		put_item(OP_INIT, 1, 0, 0, 16'd0, 0);
		put_item(OP_CONTROL, 1, 32767, 32767, 16'd65535, 0);
		put_item(OP_CONTROL, 1, -32768, -32768, 16'd0, 0);
		drain();

		// Random phases, each under its own register setting. The last phase
		// runs with neither gaps nor stalls; they are switched off before its
		// register writes so that any stall burst has ended by its first item.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == RANDOM_PHASES - 1)
				gaps_on <= 1'b0;
			case (ph)
				0: configure($urandom_range(0, 32767), 65536,
					$urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24));
				1: configure(32767, 131071, $urandom, $urandom);
				// A velocity gain of 128 in Q8.24 is half a Q16.16 count per delta
				// count, which makes every odd delta a rounding tie.
				2: configure(1, 1, 0, 128);
				3: configure(0, 0, '1, '1);
				4: configure($urandom_range(0, 32767), $urandom_range(0, 131071),
					$urandom, $urandom);
				default: configure($urandom_range(0, 32767), 65536,
					$urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20));
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Once, let the pipeline empty completely in mid-phase.
				if (ph == 1 && n == ITEMS_PER_PHASE / 2)
					drain();
				random_item();
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (failures == 0)
			$display("joint_encoder_tracker_tb passed");
		else
			$display("joint_encoder_tracker_tb failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#1_000_000;
		$display("joint_encoder_tracker_tb failed");
		$finish;
	end

endmodule
